FILE: src/buddy_block_allocator_assert.svh
// Assertion macros shared by the buddy allocator RTL.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buddy allocator assertion failed");

// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buddy allocator assertion failed");

`endif

FILE: src/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
// No dependencies.
`default_nettype none

package bba_pkg;

  localparam int ROW_LG   = 6;
  localparam int ROW_BITS = 1 << ROW_LG;
  localparam int CNT_W    = 11;
  localparam int ADDR_W   = 10;
  localparam int ORDER_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  typedef struct packed {
    logic              found;
    logic [ROW_LG-1:0] idx;
  } lsb_res_t;

endpackage

`default_nettype wire

FILE: src/bba_chan_if.sv
// Request and response channel interfaces of the buddy block allocator.
// Depends on bba_pkg.
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ORDER_W-1:0] block_order;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, output req_type, output block_order,
                  output free_address, input ready);
  modport sink   (input valid, input req_type, input block_order,
                  input free_address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] alloc_address;

  modport source (output valid, output ok, output alloc_address, input ready);
  modport sink   (input valid, input ok, input alloc_address, output ready);
endinterface

`default_nettype wire

FILE: src/buddy_block_allocator.sv
// Buddy block allocator: top level with request sequencer and free counts.
// Depends on bba_pkg, bba_chan_if, bba_ram, bba_lsb and the assert header.
//
// Usage:
//  - req_i carries one word per request: req_type (0 alloc, 1 free),
//    block_order and free_address. rsp_o returns one word per request:
//    ok and alloc_address (zero for frees and failed allocations).
//  - The free bitmaps of all orders live in one 64-bit-wide row memory;
//    one shared read-modify-write path and a lowest-bit finder do all
//    the work, one bitmap row per step.
//  - Allocation searches upward for an order with a nonzero count, scans
//    that order's rows for a free bit, then splits down to the order
//    asked for. Free merges upward while the buddy is free. An order out
//    of range goes straight to the response. Each split or merge step is
//    a read state then a write state, since the memory read is registered.
//  - One request is in flight at a time; req_i.ready is high only while
//    the sequencer is idle.
//  - After reset, a clearing pass writes every bitmap row (37 rows at
//    HI_ORDER = 10); req_i.ready stays low meanwhile.
//  - The response sits in an output register; a stalled receiver holds it,
//    the next request may be accepted and is held at its end until the
//    register frees up.
`default_nettype none

`include "buddy_block_allocator_assert.svh"

module buddy_block_allocator import bba_pkg::*; #(
  parameter int HI_ORDER = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bba_req_if.sink     req_i,
  bba_rsp_if.source   rsp_o
);

  // Rows of bitmap needed at order o.
  function automatic int rows_f(int o);
    return ((1 << (HI_ORDER - o)) + ROW_BITS - 1) >> ROW_LG;
  endfunction

  // First row of order o.
  function automatic int base_f(int o);
    int b;
    b = 0;
    for (int i = 0; i < o; i++) begin
      b += rows_f(i);
    end
    return b;
  endfunction

  localparam int DEPTH = base_f(HI_ORDER + 1);
  localparam int RAW   = $clog2(DEPTH);
  localparam int OW    = $clog2(HI_ORDER + 2);
  localparam int CW    = $clog2(HI_ORDER + 1);
  localparam int SXW   = (HI_ORDER > ROW_LG) ? HI_ORDER : ROW_LG;

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_SRCH     = 4'd2;
  localparam logic [3:0] ST_SCAN_CHK = 4'd3;
  localparam logic [3:0] ST_SPLIT_RD = 4'd4;
  localparam logic [3:0] ST_SPLIT_WR = 4'd5;
  localparam logic [3:0] ST_FREE_RD  = 4'd6;
  localparam logic [3:0] ST_FREE_CHK = 4'd7;
  localparam logic [3:0] ST_DONE     = 4'd8;

  // Row tables per order.
  logic [RAW-1:0] base_tab [HI_ORDER+1];
  logic [RAW-1:0] last_tab [HI_ORDER+1];

  for (genvar g = 0; g <= HI_ORDER; g++) begin : g_tab
    assign base_tab[g] = RAW'(base_f(g));
    assign last_tab[g] = RAW'(base_f(g + 1) - 1);
  end

  logic [3:0]        st_q, st_d;
  logic [RAW-1:0]    clr_q, clr_d;
  logic [OW-1:0]     o_q, o_d;
  logic [OW-1:0]     ord_q, ord_d;
  logic [SXW-1:0]    seg_q, seg_d;
  logic [RAW-1:0]    row_q, row_d;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              rsp_vld_q, rsp_vld_d;
  logic              rsp_ok_q, rsp_ok_d;
  logic [ADDR_W-1:0] rsp_addr_q, rsp_addr_d;
  logic [CNT_W-1:0]  cnt_q [HI_ORDER+1];

  logic [1:0]          cnt_op;
  logic [CW-1:0]       cnt_sel;
  logic                mem_we;
  logic [RAW-1:0]      mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic [RAW-1:0]      mem_raddr;
  logic [ROW_BITS-1:0] mem_rdata;
  lsb_res_t            lsb;

  logic [CW-1:0]     o_idx;
  logic [CW-1:0]     dn_idx;
  logic [RAW-1:0]    cur_base;
  logic [RAW-1:0]    cur_last;
  logic [ROW_LG-1:0] bit_sel;
  logic [ROW_LG-1:0] bud_bit;
  logic [SXW-1:0]    scan_seg;
  logic [SXW-1:0]    split_bud;

  assign o_idx     = o_q[CW-1:0];
  assign dn_idx    = CW'(o_q - 1'b1);
  assign cur_base  = base_tab[o_idx];
  assign cur_last  = last_tab[o_idx];
  assign bit_sel   = seg_q[ROW_LG-1:0];
  assign bud_bit   = {bit_sel[ROW_LG-1:1], ~bit_sel[0]};
  assign scan_seg  = SXW'({RAW'(row_q - cur_base), lsb.idx});
  assign split_bud = {seg_q[SXW-2:0], 1'b1};

  bba_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ROW_BITS),
    .AW    (RAW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bba_lsb u_lsb (
    .data_i (mem_rdata),
    .res_o  (lsb)
  );

  assign req_i.ready         = (st_q == ST_IDLE);
  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.ok            = rsp_ok_q;
  assign rsp_o.alloc_address = rsp_addr_q;

  always_comb begin
    st_d       = st_q;
    clr_d      = clr_q;
    o_d        = o_q;
    ord_d      = ord_q;
    seg_d      = seg_q;
    row_d      = row_q;
    ok_d       = ok_q;
    res_addr_d = res_addr_q;
    rsp_ok_d   = rsp_ok_q;
    rsp_addr_d = rsp_addr_q;
    // drop the response once taken
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    cnt_op     = CNT_NONE;
    cnt_sel    = o_idx;
    mem_we     = 1'b0;
    mem_waddr  = row_q;
    mem_wdata  = mem_rdata;
    mem_raddr  = row_q;

    unique case (st_q)
      ST_CLR: begin
        // write reset rows: only the single top-order row holds a free bit
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == RAW'(DEPTH - 1)) ? ROW_BITS'(1) : '0;
        if (clr_q == RAW'(DEPTH - 1)) begin
          st_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          ok_d       = 1'b0;
          res_addr_d = '0;
          if (32'(req_i.block_order) > HI_ORDER) begin
            st_d = ST_DONE;
          end else begin
            o_d   = OW'(req_i.block_order);
            ord_d = OW'(req_i.block_order);
            if (req_i.req_type == REQ_ALLOC) begin
              st_d = ST_SRCH;
            end else begin
              seg_d = SXW'((32'(req_i.free_address) >> req_i.block_order) &
                           ((32'd1 << (HI_ORDER - 32'(req_i.block_order))) - 32'd1));
              st_d  = ST_FREE_RD;
            end
          end
        end
      end

      ST_SRCH: begin
        // walk up one order per cycle until a nonzero count
        if (32'(o_q) > HI_ORDER) begin
          st_d = ST_DONE;
        end else if (cnt_q[o_idx] != '0) begin
          mem_raddr = cur_base;
          row_d     = cur_base;
          st_d      = ST_SCAN_CHK;
        end else begin
          o_d = o_q + 1'b1;
        end
      end

      ST_SCAN_CHK: begin
        if (lsb.found) begin
          // take the lowest free block and clear its bit
          seg_d     = scan_seg;
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(ROW_BITS'(1) << lsb.idx);
          cnt_op    = CNT_DEC;
          if (o_q > ord_q) begin
            st_d = ST_SPLIT_RD;
          end else begin
            ok_d       = 1'b1;
            res_addr_d = ADDR_W'(32'(scan_seg) << ord_q);
            st_d       = ST_DONE;
          end
        end else if (row_q == cur_last) begin
          // count without a free bit: fail with no change
          st_d = ST_DONE;
        end else begin
          row_d     = row_q + 1'b1;
          mem_raddr = row_q + 1'b1;
        end
      end

      ST_SPLIT_RD: begin
        // step down one order; fetch the row of the split-off buddy
        o_d       = o_q - 1'b1;
        seg_d     = {seg_q[SXW-2:0], 1'b0};
        row_d     = base_tab[dn_idx] + RAW'(split_bud >> ROW_LG);
        mem_raddr = base_tab[dn_idx] + RAW'(split_bud >> ROW_LG);
        st_d      = ST_SPLIT_WR;
      end

      ST_SPLIT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | (ROW_BITS'(1) << {bit_sel[ROW_LG-1:1], 1'b1});
        cnt_op    = CNT_INC;
        if (o_q == ord_q) begin
          ok_d       = 1'b1;
          res_addr_d = ADDR_W'(32'(seg_q) << ord_q);
          st_d       = ST_DONE;
        end else begin
          st_d = ST_SPLIT_RD;
        end
      end

      ST_FREE_RD: begin
        // block and buddy share one row
        mem_raddr = cur_base + RAW'(seg_q >> ROW_LG);
        row_d     = cur_base + RAW'(seg_q >> ROW_LG);
        st_d      = ST_FREE_CHK;
      end

      ST_FREE_CHK: begin
        mem_we = 1'b1;
        if (32'(o_q) < HI_ORDER && mem_rdata[bud_bit]) begin
          // merge: claim the buddy and advance one order
          mem_wdata = mem_rdata & ~(ROW_BITS'(1) << bud_bit);
          cnt_op    = CNT_DEC;
          seg_d     = seg_q >> 1;
          o_d       = o_q + 1'b1;
          st_d      = ST_FREE_RD;
        end else begin
          mem_wdata = mem_rdata | (ROW_BITS'(1) << bit_sel);
          cnt_op    = CNT_INC;
          ok_d      = 1'b1;
          st_d      = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d  = 1'b1;
          rsp_ok_d   = ok_q;
          rsp_addr_d = res_addr_q;
          st_d       = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLR;
      clr_q     <= '0;
      rsp_vld_q <= 1'b0;
      for (int i = 0; i <= HI_ORDER; i++) begin
        cnt_q[i] <= (i == HI_ORDER) ? CNT_W'(1) : '0;
      end
    end else begin
      st_q      <= st_d;
      clr_q     <= clr_d;
      rsp_vld_q <= rsp_vld_d;
      for (int i = 0; i <= HI_ORDER; i++) begin
        if (cnt_sel == CW'(i)) begin
          if (cnt_op == CNT_INC && cnt_q[i] != CNT_MAX) begin
            cnt_q[i] <= cnt_q[i] + 1'b1;
          end else if (cnt_op == CNT_DEC && cnt_q[i] != '0) begin
            cnt_q[i] <= cnt_q[i] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    o_q        <= o_d;
    ord_q      <= ord_d;
    seg_q      <= seg_d;
    row_q      <= row_d;
    ok_q       <= ok_d;
    res_addr_q <= res_addr_d;
    rsp_ok_q   <= rsp_ok_d;
    rsp_addr_q <= rsp_addr_d;
  end

  `BBA_ASSERT_IMP(a_scan_in_order, st_q == ST_SCAN_CHK,
                  row_q >= cur_base && row_q <= cur_last)
  `BBA_ASSERT_NXT(a_bad_order,
                  st_q == ST_IDLE && req_i.valid && 32'(req_i.block_order) > HI_ORDER,
                  st_q == ST_DONE && !ok_q)
  `BBA_ASSERT_IMP(a_split_above_req, st_q == ST_SPLIT_WR, o_q >= ord_q)
  `BBA_ASSERT_IMP(a_free_in_range, st_q == ST_FREE_CHK, 32'(o_q) <= HI_ORDER)

endmodule

`default_nettype wire

FILE: src/bba_ram.sv
// Bitmap row store: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module bba_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 64,
  parameter int AW    = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/bba_lsb.sv
// Lowest-set-bit finder over one bitmap row.
// Depends on bba_pkg.
`default_nettype none

module bba_lsb import bba_pkg::*; (
  input  logic [ROW_BITS-1:0] data_i,
  output lsb_res_t            res_o
);

  always_comb begin
    res_o = '0;
    // scan from the top so the lowest set bit wins
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (data_i[i]) begin
        res_o.found = 1'b1;
        res_o.idx   = ROW_LG'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_buddy_block_allocator.sv
// Testbench of the buddy block allocator: directed table, then random alloc/free traffic.
// Depends on bba_pkg, bba_chan_if and buddy_block_allocator.
`default_nettype none

module tb_buddy_block_allocator import bba_pkg::*; ();

  localparam int TOP_ORDER  = 10;
  localparam int WORD_BITS  = 64;
  localparam int MAP_SLOTS  = 1 << (TOP_ORDER + 1);
  localparam int SUM_SLOTS  = 64;
  localparam int RAND_ITEMS = 1100;

  typedef struct packed {
    logic              req_type;
    logic [ORDER_W-1:0] block_order;
    logic [ADDR_W-1:0] free_address;
  } req_word_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] alloc_address;
  } rsp_word_t;

  // Directed row: request, plus optional typed-in response.
  typedef struct packed {
    req_word_t req;
    logic      has_exp;
    rsp_word_t exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  buddy_block_allocator #(.HI_ORDER(TOP_ORDER)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow allocator state.
  logic             free_bits [MAP_SLOTS];
  logic             row_flags [SUM_SLOTS];
  logic [CNT_W-1:0] order_cnt [TOP_ORDER+1];

  rsp_word_t pending_rsp [$];
  rsp_word_t typed_rsp   [$];
  logic      typed_valid [$];
  int        live_addr   [$];
  int        live_order  [$];
  int        err_cnt;
  int        rsp_seen;
  int        frees_sent;
  bit        stall_hold;
  bit        no_idle;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int blocks_at(int o);
    return 1 << (TOP_ORDER - o);
  endfunction

  function automatic int map_base(int o);
    return MAP_SLOTS - (1 << (TOP_ORDER - o + 1));
  endfunction

  function automatic int words_at(int o);
    return (blocks_at(o) + WORD_BITS - 1) / WORD_BITS;
  endfunction

  function automatic int sum_base(int o);
    int b;
    b = 0;
    for (int i = 0; i < o; i++) b += words_at(i);
    return b;
  endfunction

  function automatic logic bit_get(int o, int idx);
    if (idx >= blocks_at(o)) return 1'b0;
    return free_bits[map_base(o) + idx];
  endfunction

  function automatic void bit_put(int o, int idx, logic v);
    if (idx < blocks_at(o)) free_bits[map_base(o) + idx] = v;
  endfunction

  function automatic void flag_put(int o, int w, logic v);
    if (w < words_at(o)) row_flags[sum_base(o) + w] = v;
  endfunction

  // Drop the row flag once its row holds no free block.
  function automatic void tidy_flag(int o, int idx);
    int w, lo, hi;
    w  = idx / WORD_BITS;
    lo = w * WORD_BITS;
    hi = lo + WORD_BITS;
    if (hi > blocks_at(o)) hi = blocks_at(o);
    for (int i = lo; i < hi; i++)
      if (bit_get(o, i)) return;
    flag_put(o, w, 1'b0);
  endfunction

  function automatic void cnt_up(int o);
    if (order_cnt[o] != CNT_MAX) order_cnt[o]++;
  endfunction

  function automatic void cnt_down(int o);
    if (order_cnt[o] != '0) order_cnt[o]--;
  endfunction

  function automatic bit lowest_free(int o, output int idx);
    int w;
    idx = 0;
    for (w = 0; w < words_at(o); w++)
      if (row_flags[sum_base(o) + w]) break;
    if (w == words_at(o)) return 1'b0;
    for (int i = w * WORD_BITS; i < blocks_at(o); i++)
      if (bit_get(o, i)) begin
        idx = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic void shadow_reset();
    foreach (free_bits[i]) free_bits[i] = 1'b0;
    foreach (row_flags[i]) row_flags[i] = 1'b0;
    foreach (order_cnt[i]) order_cnt[i] = '0;
    bit_put(TOP_ORDER, 0, 1'b1);
    flag_put(TOP_ORDER, 0, 1'b1);
    order_cnt[TOP_ORDER] = 1;
  endfunction

  // Advance the shadow state by one request and return its response.
  function automatic rsp_word_t buddy_predict(req_word_t r);
    rsp_word_t res;
    int o, seg, ord;
    res = '0;
    ord = r.block_order;
    if (ord > TOP_ORDER) return res;
    if (r.req_type == REQ_ALLOC) begin
      for (o = ord; o <= TOP_ORDER; o++)
        if (order_cnt[o] != '0) break;
      if (o > TOP_ORDER) return res;
      if (!lowest_free(o, seg)) return res;
      bit_put(o, seg, 1'b0);
      tidy_flag(o, seg);
      cnt_down(o);
      while (o > ord) begin
        o--;
        seg = seg << 1;
        bit_put(o, seg ^ 1, 1'b1);
        flag_put(o, (seg ^ 1) / WORD_BITS, 1'b1);
        cnt_up(o);
      end
      res.ok = 1'b1;
      res.alloc_address = ADDR_W'(seg << ord);
      return res;
    end
    o   = ord;
    seg = (int'(r.free_address) >> o) & (blocks_at(o) - 1);
    while (o < TOP_ORDER && bit_get(o, seg ^ 1)) begin
      bit_put(o, seg ^ 1, 1'b0);
      tidy_flag(o, seg ^ 1);
      cnt_down(o);
      seg = seg >> 1;
      o++;
    end
    bit_put(o, seg, 1'b1);
    flag_put(o, seg / WORD_BITS, 1'b1);
    cnt_up(o);
    res.ok = 1'b1;
    return res;
  endfunction

  function automatic req_word_t mk_req(logic t, int ord, int addr);
    req_word_t r;
    r.req_type     = t;
    r.block_order  = ORDER_W'(ord);
    r.free_address = ADDR_W'(addr);
    return r;
  endfunction

  function automatic dir_row_t mk_row(req_word_t r, logic he, logic ok, int addr);
    dir_row_t d;
    d.req     = r;
    d.has_exp = he;
    d.exp.ok  = ok;
    d.exp.alloc_address = ADDR_W'(addr);
    return d;
  endfunction

  // Hand one word to the block; the prediction is made at acceptance.
  // Valid stays high after acceptance until the next idle cycle or a drain.
  task automatic send_word(req_word_t r, logic he, rsp_word_t ex);
    rsp_word_t p;
    while (!no_idle && $urandom_range(99) < 37) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.req_type;
    req_if.block_order  <= r.block_order;
    req_if.free_address <= r.free_address;
    do @(posedge clk_i); while (!req_if.ready);
    p = buddy_predict(r);
    pending_rsp.push_back(p);
    typed_rsp.push_back(ex);
    typed_valid.push_back(he);
    if (r.req_type == REQ_ALLOC && p.ok) begin
      live_addr.push_back(p.alloc_address);
      live_order.push_back(r.block_order);
    end
    if (r.req_type == REQ_FREE) frees_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random idling, plus a long hold-off when asked.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_seen++;
        if (pending_rsp.size() == 0) begin
          $error("response with no request waiting");
          err_cnt++;
        end else begin
          rsp_word_t ex;
          rsp_word_t tp;
          logic tv;
          ex = pending_rsp.pop_front();
          tp = typed_rsp.pop_front();
          tv = typed_valid.pop_front();
          if (tv && tp != ex) begin
            $error("table row disagrees: typed %h, predicted %h", tp, ex);
            err_cnt++;
          end
          if (rsp_if.ok !== ex.ok) begin
            $error("ok: expected %0d, actual %0d", ex.ok, rsp_if.ok);
            err_cnt++;
          end
          if (rsp_if.alloc_address !== ex.alloc_address) begin
            $error("alloc_address: expected %0d, actual %0d",
                   ex.alloc_address, rsp_if.alloc_address);
            err_cnt++;
          end
        end
      end
      if (stall_hold) begin
        rsp_if.ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(posedge clk_i);
        stall_hold = 1'b0;
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= no_idle || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    dir_row_t  dir_tab [$];
    req_word_t r;
    rsp_word_t none;
    int        k, a, o, u;
    int        sent;

    none         = '0;
    err_cnt      = 0;
    rsp_seen     = 0;
    frees_sent   = 0;
    stall_hold   = 1'b0;
    no_idle      = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_ALLOC;
    req_if.block_order  = '0;
    req_if.free_address = '0;
    shadow_reset();

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: typed responses only where obvious.
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 10, 0), 1, 1, 0));    // whole store
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 0, 0), 1, 0, 0));     // nothing left
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 10, 1023), 1, 1, 0));  // top free, low bits ignored
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 11, 0), 1, 0, 0));    // order out of range
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 15, 1023), 1, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 15, 1023), 1, 0, 0));  // ignored free
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 0, 0), 1, 1, 0));     // full split chain
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 0, 1023), 1, 1, 1));
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 9, 0), 1, 1, 512));
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 3, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 0, 1), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 0, 0), 0, 0, 0));      // merge upward
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 9, 512), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 3, 8), 0, 0, 0));      // back to one top block
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 0, 5), 0, 0, 0));      // double free
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 0, 5), 0, 0, 0));      // count without a bit
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 0, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 0, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_ALLOC, 10, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 10, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(mk_req(REQ_FREE, 10, 0), 0, 0, 0));

    foreach (dir_tab[i]) send_word(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);
    wait_drained();
    live_addr.delete();
    live_order.delete();

    // Random traffic: mostly allocs and frees of live blocks, some noise.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent == 200) stall_hold = 1'b1;
      if (sent == 400) no_idle = 1'b1;
      if (sent == 550) no_idle = 1'b0;
      if (sent == 700) wait_drained();
      u = $urandom_range(99);
      if (u < 8) begin
        r = mk_req($urandom_range(1), $urandom_range(15), $urandom_range(1023));
      end else if (u < 55 || live_addr.size() == 0) begin
        o = ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(4);
        r = mk_req(REQ_ALLOC, o, $urandom_range(1023));
      end else begin
        k = $urandom_range(live_addr.size() - 1);
        a = live_addr[k];
        o = live_order[k];
        live_addr.delete(k);
        live_order.delete(k);
        // Junk in the ignored low bits.
        a = a | ($urandom_range(1023) & ((1 << o) - 1));
        r = mk_req(REQ_FREE, o, a);
      end
      send_word(r, 1'b0, none);
      sent++;
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      err_cnt++;
    end
    $display("Covered %0d responses over %0d directed and %0d random requests",
             rsp_seen, dir_tab.size(), RAND_ITEMS);
    $display("including %0d frees, a long receiver stall and a full drain.", frees_sent);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/bba_pkg.sv
src/bba_chan_if.sv
src/bba_ram.sv
src/bba_lsb.sv
src/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
